// ===== sv/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types and constants of the error diffusion dither: configuration
// record, register indexes, controller command and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package edd_pkg;

    localparam int PIX_W      = 8;
    localparam int LEVEL_W    = 8;
    localparam int ROW_LEN_W  = 11;
    localparam int ROW_CNT_W  = 12;
    localparam int LEVELS_W   = 9;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int DIV_STEPS  = 8;

    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_LEVELS     = 2'd2;

    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 11'd640;
    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST  = 12'd480;
    localparam logic [LEVELS_W-1:0]  LEVELS_RST     = 9'd2;

    // floor(x / 255) = (x * RECIP_255) >> RECIP_SHIFT for any 16-bit x
    localparam logic [15:0] RECIP_255   = 16'h8081;
    localparam int          RECIP_SHIFT = 23;

    typedef struct packed {
        logic [ROW_LEN_W-1:0] row_length;
        logic [ROW_CNT_W-1:0] row_count;
        logic [LEVELS_W-1:0]  levels;
    } edd_cfg_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic sum;
        logic mul;
        logic level;
        logic div_load;
        logic div_step;
        logic share;
        logic update;
        logic tail;
        logic emit;
    } edd_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic tail_needed;
        logic out_free;
    } edd_status_t;

endpackage

`default_nettype wire

// ===== sv/edd_ram.sv =====
// ----------------------------------------------------------------------------
// edd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/edd_ctrl.sv =====
// ----------------------------------------------------------------------------
// edd_ctrl
// Sequencer of the dither: line store clearing pass after reset, then one
// pixel at a time: sum, scale, level, divide, share, update, [tail,] emit.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire edd_pkg::edd_status_t  status,
    output edd_pkg::edd_cmd_t          cmd
);
    import edd_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SUM      = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_LEVEL    = 4'd4;
    localparam logic [3:0] S_DIV_LOAD = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_SHARE    = 4'd7;
    localparam logic [3:0] S_UPDATE   = 4'd8;
    localparam logic [3:0] S_TAIL     = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_SHARE;
                end
            end
            S_SHARE:
            begin
                cmd.share  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.tail_needed ? S_TAIL : S_EMIT;
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/edd_dp.sv =====
// ----------------------------------------------------------------------------
// edd_dp
// Datapath of the dither: line store, error accumulators, level choice by
// reciprocal, restoring divider for the output value, error shares and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire edd_pkg::edd_cfg_t             cfg,
    input  wire edd_pkg::edd_cmd_t             cmd,
    output edd_pkg::edd_status_t               status,
    input  wire logic [edd_pkg::PIX_W-1:0]     pix_in,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [2*edd_pkg::LEVEL_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import edd_pkg::*;

    localparam int ACC  = FRAC_BITS + 10;
    localparam int EXW  = ACC + 4;
    localparam int VCW  = FRAC_BITS + 8;
    localparam int TW   = VCW + 8;
    localparam int UW   = FRAC_BITS + 17;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
    localparam int HW   = ROW_CNT_W + 1;
    localparam int FULL = 255 << FRAC_BITS;
    localparam int HALF = 255 << (FRAC_BITS - 1);

    localparam logic signed [EXW-1:0] SAT_HI = {{5{1'b0}}, {(ACC-1){1'b1}}};
    localparam logic signed [EXW-1:0] SAT_LO = {{5{1'b1}}, {(ACC-1){1'b0}}};
    localparam logic signed [ACC-1:0] FULL_A = ACC'(FULL);

    function automatic logic signed [ACC-1:0] sat_acc(input logic signed [EXW-1:0] x);
        if (x > SAT_HI)
        begin
            return SAT_HI[ACC-1:0];
        end
        else if (x < SAT_LO)
        begin
            return SAT_LO[ACC-1:0];
        end
        return x[ACC-1:0];
    endfunction

    // control state
    logic signed [ACC-1:0] right_reg, right_next;
    logic signed [ACC-1:0] pb_reg, pb_next;
    logic signed [ACC-1:0] pbr_reg, pbr_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [ROW_CNT_W-1:0]  row_reg, row_next;
    logic [CW-1:0]         clear_cnt_reg, clear_cnt_next;
    logic [2:0]            div_cnt_reg, div_cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [PIX_W-1:0]      pix_reg;
    logic [CW-1:0]         col_cur_reg;
    logic                  last_col_reg, last_row_reg, row_nz_reg;
    logic [LEVEL_W-1:0]    span_reg;
    logic signed [ACC-1:0] v_reg;
    logic [TW-1:0]         t_reg;
    logic [LEVEL_W-1:0]    k_reg;
    logic [16:0]           rem_reg;
    logic [15:0]           dsh_reg;
    logic [LEVEL_W-1:0]    q_reg;
    logic signed [ACC-1:0] e7_reg, e3_reg, e5_reg, e1_reg;
    logic [LEVEL_W-1:0]    out_k_reg, out_q_reg;
    logic                  out_eor_reg, out_eof_reg;

    // geometry and span
    logic [WW-1:0]         row_len_x, w_eff, col_p1;
    logic [HW-1:0]         h_eff, row_p1;
    logic [LEVELS_W-1:0]   lv_eff;
    logic [LEVEL_W-1:0]    span;
    logic                  last_col, last_row;

    // line store
    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [ACC-1:0]        ram_wdata;
    logic [ACC-1:0]        ram_rdata;

    // arithmetic
    logic signed [EXW-1:0] v_sum;
    logic [VCW-1:0]        vc;
    logic [UW-1:0]         u_val;
    logic [31:0]           recip_prod;
    logic [8:0]            k_raw;
    logic [LEVEL_W-1:0]    k_val;
    logic                  div_ge;
    logic signed [EXW-1:0] err_x, e7_x, e3_x, e5_x;

    always_comb
    begin
        row_len_x = WW'(cfg.row_length);
        if (row_len_x == '0)
        begin
            w_eff = WW'(1);
        end
        else if (row_len_x > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = row_len_x;
        end
        h_eff  = (cfg.row_count == '0) ? HW'(1) : HW'(cfg.row_count);
        col_p1 = WW'(col_reg) + WW'(1);
        row_p1 = HW'(row_reg) + HW'(1);
        last_col = (col_p1 >= w_eff);
        last_row = (row_p1 >= h_eff);
        if (cfg.levels < LEVELS_W'(2))
        begin
            lv_eff = LEVELS_W'(2);
        end
        else if (cfg.levels > LEVELS_W'(256))
        begin
            lv_eff = LEVELS_W'(256);
        end
        else
        begin
            lv_eff = cfg.levels;
        end
        span = LEVEL_W'(lv_eff - LEVELS_W'(1));
    end

    edd_ram #(
        .WIDTH (ACC),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        v_sum = EXW'({pix_reg, {FRAC_BITS{1'b0}}}) + EXW'(right_reg);
        if (row_nz_reg)
        begin
            v_sum = v_sum + EXW'($signed(ram_rdata));
        end

        if (v_reg[ACC-1])
        begin
            vc = '0;
        end
        else if (v_reg > FULL_A)
        begin
            vc = VCW'(FULL);
        end
        else
        begin
            vc = v_reg[VCW-1:0];
        end

        u_val      = UW'(t_reg) + UW'(HALF - 1);
        recip_prod = 32'(u_val[FRAC_BITS+15:FRAC_BITS]) * 32'(RECIP_255);
        k_raw      = recip_prod[31:RECIP_SHIFT];
        if (t_reg <= TW'(HALF))
        begin
            k_val = '0;
        end
        else if (k_raw > {1'b0, span_reg})
        begin
            k_val = span_reg;
        end
        else
        begin
            k_val = k_raw[LEVEL_W-1:0];
        end

        div_ge = ({1'b0, dsh_reg} <= rem_reg);

        err_x = EXW'(v_reg) - EXW'({1'b0, q_reg, {FRAC_BITS{1'b0}}});
        e7_x  = (err_x <<< 3) - err_x;
        e3_x  = (err_x <<< 1) + err_x;
        e5_x  = (err_x <<< 2) + err_x;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clear_cnt_reg;
        ram_wdata = '0;
        if (cmd.clear)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.update)
        begin
            ram_we    = !last_row_reg && (col_cur_reg != '0);
            ram_waddr = col_cur_reg - CW'(1);
            ram_wdata = sat_acc(EXW'(pb_reg) + EXW'(e3_reg));
        end
        else if (cmd.tail)
        begin
            ram_we    = 1'b1;
            ram_waddr = col_cur_reg;
            ram_wdata = pb_reg;
        end
    end

    always_comb
    begin
        right_next     = right_reg;
        pb_next        = pb_reg;
        pbr_next       = pbr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        clear_cnt_next = clear_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;

        if (cmd.clear)
        begin
            clear_cnt_next = clear_cnt_reg + CW'(1);
        end
        if (cmd.div_load)
        begin
            div_cnt_next = 3'(DIV_STEPS - 1);
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg - 3'd1;
        end
        if (cmd.update)
        begin
            right_next = last_col_reg ? '0 : e7_reg;
            if (!last_row_reg)
            begin
                pb_next  = sat_acc(EXW'(pbr_reg) + EXW'(e5_reg));
                pbr_next = last_col_reg ? '0 : e1_reg;
            end
            else
            begin
                pb_next  = '0;
                pbr_next = '0;
            end
            if (last_col_reg)
            begin
                col_next = '0;
                row_next = last_row_reg ? '0 : row_reg + ROW_CNT_W'(1);
            end
            else
            begin
                col_next = col_cur_reg + CW'(1);
            end
        end
        if (cmd.tail)
        begin
            pb_next  = '0;
            pbr_next = '0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg     <= '0;
            pb_reg        <= '0;
            pbr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            clear_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            right_reg     <= right_next;
            pb_reg        <= pb_next;
            pbr_reg       <= pbr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            clear_cnt_reg <= clear_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg      <= pix_in;
            col_cur_reg  <= col_reg;
            last_col_reg <= last_col;
            last_row_reg <= last_row;
            row_nz_reg   <= (row_reg != '0);
            span_reg     <= span;
        end
        if (cmd.sum)
        begin
            v_reg <= sat_acc(v_sum);
        end
        if (cmd.mul)
        begin
            t_reg <= TW'(vc) * TW'(span_reg);
        end
        if (cmd.level)
        begin
            k_reg <= k_val;
        end
        if (cmd.div_load)
        begin
            rem_reg <= 17'({k_reg, 9'd0}) - 17'({k_reg, 1'b0}) + 17'(span_reg);
            dsh_reg <= {span_reg, 8'd0};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - {1'b0, dsh_reg};
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[LEVEL_W-2:0], div_ge};
        end
        if (cmd.share)
        begin
            e7_reg <= sat_acc(e7_x >>> 4);
            e3_reg <= sat_acc(e3_x >>> 4);
            e5_reg <= sat_acc(e5_x >>> 4);
            e1_reg <= sat_acc(err_x >>> 4);
        end
        if (cmd.emit)
        begin
            out_k_reg   <= k_reg;
            out_q_reg   <= q_reg;
            out_eor_reg <= last_col_reg;
            out_eof_reg <= last_col_reg && last_row_reg;
        end
    end

    assign status.clear_last  = (clear_cnt_reg == CW'(MAX_WIDTH - 1));
    assign status.div_last    = (div_cnt_reg == 3'd0);
    assign status.tail_needed = last_col_reg && !last_row_reg;
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_q_reg, out_k_reg};
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = out_eof_reg;

endmodule

`default_nettype wire

// ===== sv/error_diffusion_dither.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg error diffusion of an 8-bit luminance stream onto a
// configured number of evenly spaced levels.
//
//   channel   | role        | handshake               | payload
//   ----------+-------------+-------------------------+------------------------
//   s_*       | pixel in    | s_tvalid / s_tready     | s_tdata pixel_value
//   m_*       | result out  | m_tvalid / m_tready     | m_tdata, m_tlast, m_tuser
//   APB       | registers   | psel / penable / pready | row_length, row_count,
//             |             |                         | levels
//
// A pixel is taken only while the sequencer is idle, so the next pixel waits
// until the current one has passed every step; the last pixel of a row other
// than the last row of the frame adds a tail step, as the line store has a
// single write port. s_tready and m_tvalid rise together after the emit step.
// The divide step uses the 8-step restoring divider for the output value.
// After reset a clearing pass writes zero to all MAX_WIDTH line store entries
// before the first pixel is taken.
// A held result on the output register stalls only the final step of the
// next pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module error_diffusion_dither #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] pixel_value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,   // [7:0] level_index,
                                                              // [15:8] quantized_value
    output logic                                   m_tlast,   // end_of_row
    output logic                                   m_tuser,   // [0] end_of_frame
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [edd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [edd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [edd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import edd_pkg::*;

    edd_cfg_t    cfg_reg;
    edd_cfg_t    cfg_next;
    edd_cmd_t    cmd;
    edd_status_t status;

    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_ROW_LENGTH: cfg_next.row_length = pwdata[ROW_LEN_W-1:0];
                REG_ROW_COUNT:  cfg_next.row_count  = pwdata[ROW_CNT_W-1:0];
                REG_LEVELS:     cfg_next.levels     = pwdata[LEVELS_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROW_LENGTH: prdata = APB_DATA_W'(cfg_reg.row_length);
            REG_ROW_COUNT:  prdata = APB_DATA_W'(cfg_reg.row_count);
            REG_LEVELS:     prdata = APB_DATA_W'(cfg_reg.levels);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length <= ROW_LENGTH_RST;
            cfg_reg.row_count  <= ROW_COUNT_RST;
            cfg_reg.levels     <= LEVELS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    edd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edd_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .pix_in   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/edd_checker.sv =====
// ----------------------------------------------------------------------------
// edd_checker
// Port-level checks of the dither, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_frame_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of row");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_black_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:0] == 8'd0) |-> (m_tdata[15:8] == 8'd0))
        else $error("level zero with non-zero luminance");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_error_diffusion_dither.sv =====
// ----------------------------------------------------------------------------
// tb_error_diffusion_dither
// Self-checking bench for the error diffusion dither. A directed table covers
// reset defaults, field extremes, out-of-range register values and geometry
// shrunk mid-frame; random phases then sweep frame sizes and level counts.
// Every accepted pixel is run through a local fixed-point diffusion model
// and each output request is compared field by field, in order, while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_error_diffusion_dither;
    timeunit 1ns;
    timeprecision 1ps;

    import edd_pkg::*;

    localparam int     LINE_DEPTH   = 1024;
    localparam int     LINE_AW      = $clog2(LINE_DEPTH);
    localparam int     FRAC         = 4;
    localparam longint FRAC_ONE     = longint'(1) << FRAC;
    localparam longint FULL_SCALE   = 255 * FRAC_ONE;
    localparam longint ACC_HI       = (longint'(1) << (FRAC + 9)) - 1;
    localparam longint ACC_LO       = -ACC_HI - 1;
    localparam int     RANDOM_ITEMS = 900;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_index;
        logic [PIX_W-1:0]   quantized_value;
        logic               end_of_row;
        logic               end_of_frame;
    } dither_res_t;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        typed;
        dither_res_t res;
    } dir_step_t;

    typedef enum logic [1:0] {STYLE_UNIFORM, STYLE_EXTREME, STYLE_RAMP, STYLE_FLAT} pix_style_t;
    typedef enum logic [1:0] {READY_HIGH, READY_COIN, READY_RUNS} ready_mode_t;

    localparam dither_res_t UNCHECKED = '0;

    // reg_idx is ignored on pixel rows
    localparam int NUM_DIRECTED = 40;
    localparam dir_step_t DIRECTED_STEPS [NUM_DIRECTED] = '{
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd0,    1'b1, '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd255,  1'b1, '{8'd1,   8'd255, 1'b0, 1'b0}},
        '{STEP_WRITE, REG_ROW_LENGTH, 32'd2,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd128,  1'b1, '{8'd1,   8'd255, 1'b1, 1'b0}},
        '{STEP_WRITE, REG_ROW_COUNT,  32'd1,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd0,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd255,  1'b0, UNCHECKED},
        '{STEP_WRITE, REG_LEVELS,     32'd256,  1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_LENGTH, 32'd3,    1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_COUNT,  32'd2,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd0,    1'b1, '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd255,  1'b1, '{8'd255, 8'd255, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd77,   1'b1, '{8'd77,  8'd77,  1'b1, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd1,    1'b1, '{8'd1,   8'd1,   1'b0, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd254,  1'b1, '{8'd254, 8'd254, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd128,  1'b1, '{8'd128, 8'd128, 1'b1, 1'b1}},
        '{STEP_WRITE, REG_LEVELS,     32'd1,    1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_LENGTH, 32'd0,    1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_COUNT,  32'd0,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd127,  1'b1, '{8'd0,   8'd0,   1'b1, 1'b1}},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd128,  1'b1, '{8'd1,   8'd255, 1'b1, 1'b1}},
        '{STEP_WRITE, REG_LEVELS,     32'd511,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd200,  1'b1, '{8'd200, 8'd200, 1'b1, 1'b1}},
        '{STEP_WRITE, REG_LEVELS,     32'd3,    1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_LENGTH, 32'd3,    1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_COUNT,  32'd3,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd255,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd0,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd128,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd64,   1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd191,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd127,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd1,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd254,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd85,   1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_LENGTH, 32'd1024, 1'b0, UNCHECKED},
        '{STEP_WRITE, REG_ROW_COUNT,  32'd4095, 1'b0, UNCHECKED},
        '{STEP_WRITE, REG_LEVELS,     32'd2,    1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd255,  1'b0, UNCHECKED},
        '{STEP_PIXEL, REG_ROW_LENGTH, 32'd0,    1'b0, UNCHECKED}
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // diffusion model state
    logic [ROW_LEN_W-1:0] cfg_row_length = ROW_LENGTH_RST;
    logic [ROW_CNT_W-1:0] cfg_row_count  = ROW_COUNT_RST;
    logic [LEVELS_W-1:0]  cfg_levels     = LEVELS_RST;
    longint               line_err [LINE_DEPTH];
    longint               err_right       = 0;
    longint               acc_below       = 0;
    longint               acc_below_right = 0;
    longint               col_pos         = 0;
    longint               row_pos         = 0;

    dither_res_t dithered [$];

    int unsigned burst_left     = 0;
    int unsigned gap_max        = 8;
    int unsigned pixels_fed     = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_done    = 0;
    int unsigned phases         = 0;
    int unsigned mismatches     = 0;

    ready_mode_t ready_mode = READY_HIGH;
    int unsigned mode_left  = 0;
    int unsigned run_left   = 0;

    error_diffusion_dither #(
        .MAX_WIDTH (LINE_DEPTH),
        .FRAC_BITS (FRAC)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        foreach (line_err[i])
            line_err[i] = 0;
    end

    function automatic longint clamp_acc(input longint x);
        if (x > ACC_HI)
            return ACC_HI;
        if (x < ACC_LO)
            return ACC_LO;
        return x;
    endfunction

    function automatic dither_res_t diffuse_pixel(input logic [PIX_W-1:0] pix);
        longint      w, h, span, v, vc, num, k, q, err, sh7, sh3, sh5, sh1;
        bit          last_col, last_row;
        dither_res_t res;
        w = longint'(cfg_row_length);
        if (w < 1)
            w = 1;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        h = longint'(cfg_row_count);
        if (h < 1)
            h = 1;
        span = longint'(cfg_levels);
        if (span < 2)
            span = 2;
        if (span > 256)
            span = 256;
        span = span - 1;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);

        v = longint'(pix);
        v = v * FRAC_ONE + err_right;
        if (row_pos > 0 && col_pos < LINE_DEPTH)
            v = v + line_err[LINE_AW'(col_pos)];
        v = clamp_acc(v);

        vc  = (v < 0) ? 0 : ((v > FULL_SCALE) ? FULL_SCALE : v);
        num = 2 * vc * span - FULL_SCALE;
        k   = (num <= 0) ? 0 : (num + 2 * FULL_SCALE - 1) / (2 * FULL_SCALE);
        if (k > span)
            k = span;
        q   = (k * 510 + span) / (2 * span);

        err = v - q * FRAC_ONE;
        sh7 = (err * 7) >>> 4;
        sh3 = (err * 3) >>> 4;
        sh5 = (err * 5) >>> 4;
        sh1 = err >>> 4;

        err_right = last_col ? 0 : clamp_acc(sh7);
        if (!last_row)
        begin
            if (col_pos > 0 && col_pos - 1 < LINE_DEPTH)
                line_err[LINE_AW'(col_pos - 1)] = clamp_acc(acc_below + sh3);
            acc_below       = clamp_acc(acc_below_right + sh5);
            acc_below_right = last_col ? 0 : clamp_acc(sh1);
            if (last_col)
            begin
                if (col_pos < LINE_DEPTH)
                    line_err[LINE_AW'(col_pos)] = acc_below;
                acc_below       = 0;
                acc_below_right = 0;
            end
        end
        else
        begin
            acc_below       = 0;
            acc_below_right = 0;
        end

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;

        res.level_index     = k[LEVEL_W-1:0];
        res.quantized_value = q[PIX_W-1:0];
        res.end_of_row      = last_col;
        res.end_of_frame    = last_col && last_row;
        return res;
    endfunction

    task automatic feed_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                              input dither_res_t typed_res);
        dither_res_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        res = diffuse_pixel(pix);
        if (typed)
            res = typed_res;
        dithered.push_back(res);
        pixels_fed++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (dithered.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(reg_idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_ROW_LENGTH: cfg_row_length = value[ROW_LEN_W-1:0];
            REG_ROW_COUNT:  cfg_row_count  = value[ROW_CNT_W-1:0];
            REG_LEVELS:     cfg_levels     = value[LEVELS_W-1:0];
            default:        ;
        endcase
        writes_done++;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // output side: stall pattern
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            mode_left  <= $urandom_range(50, 400);
            ready_mode <= ready_mode_t'($urandom_range(0, 2));
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            READY_HIGH: m_tready <= 1'b1;
            READY_COIN: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    m_tready <= ~m_tready;
                    run_left <= $urandom_range(1, 30);
                end
                else
                    run_left <= run_left - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        dither_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (dithered.size() == 0)
            begin
                $error("output request with no pixel pending: tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = dithered.pop_front();
                check_field("level_index", 32'(want.level_index), 32'(m_tdata[7:0]));
                check_field("quantized_value", 32'(want.quantized_value),
                            32'(m_tdata[15:8]));
                check_field("end_of_row", 32'(want.end_of_row), 32'(m_tlast));
                check_field("end_of_frame", 32'(want.end_of_frame), 32'(m_tuser));
            end
        end
    end

    initial
    begin
        dir_step_t   step;
        int unsigned w_eff, h_eff, n_pix, random_fed;
        logic [31:0] w_val, h_val, lv_val;
        pix_style_t  style;
        logic [7:0]  flat_val, ramp_base, ramp_step, pix;
        random_fed = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            step = DIRECTED_STEPS[i];
            if (step.kind == STEP_WRITE)
            begin
                wait_idle();
                write_reg(step.reg_idx, step.value);
            end
            else
                feed_pixel(step.value[7:0], step.typed, step.res);
        end

        while (random_fed < RANDOM_ITEMS)
        begin
            wait_idle();
            phases++;
            case ($urandom_range(0, 9))
                0:       w_val = ($urandom_range(0, 1) != 0) ? LINE_DEPTH : 32'd2047;
                1:       w_val = $urandom_range(0, 1);
                default: w_val = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_val = ($urandom_range(0, 1) != 0) ? 32'd4095 : 32'd0;
                default: h_val = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       lv_val = 256;
                1:       lv_val = 2;
                2:       lv_val = $urandom_range(0, 511);
                3, 4, 5: lv_val = $urandom_range(2, 256);
                default: lv_val = $urandom_range(3, 8);
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ROW_LENGTH, w_val);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ROW_COUNT, h_val);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_LEVELS, lv_val);

            w_eff = (cfg_row_length == 0) ? 1 :
                    ((cfg_row_length > LINE_DEPTH) ? LINE_DEPTH : 32'(cfg_row_length));
            h_eff = (cfg_row_count == 0) ? 1 : 32'(cfg_row_count);
            if (w_eff * h_eff <= 72 && $urandom_range(0, 2) != 0)
                n_pix = w_eff * h_eff;
            else
                n_pix = $urandom_range(1, 40);

            style     = pix_style_t'($urandom_range(0, 3));
            flat_val  = 8'($urandom);
            ramp_base = 8'($urandom);
            ramp_step = 8'($urandom_range(0, 40));
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 40;
            for (int i = 0; i < n_pix; i++)
            begin
                case (style)
                    STYLE_UNIFORM: pix = 8'($urandom_range(0, 255));
                    STYLE_EXTREME: pix = ($urandom_range(0, 1) != 0) ?
                                         8'(255 - $urandom_range(0, 2)) :
                                         8'($urandom_range(0, 2));
                    STYLE_RAMP:    pix = ramp_base + 8'(i) * ramp_step;
                    default:       pix = flat_val;
                endcase
                feed_pixel(pix, 1'b0, UNCHECKED);
                random_fed++;
            end
        end

        wait_idle();
        repeat (64) @(posedge clk);
        $display("%0d pixels fed, %0d results checked, %0d register writes, %0d phases",
                 pixels_fed, results_seen, writes_done, phases);
        $display("rows of 1 to 1024 pixels, frames up to 4095 rows, 2 to 256 levels");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
